>>> hw/rtl/adbm_pkg.sv
// Shared types and constants for the desktop-bus mouse register talk block.
// Used by every module under hw/rtl; depends on nothing.
package adbm_pkg;

  // Depth of the command queue between front and back
  localparam int QueueDepth = 2;

  // Request codes on the input channel
  localparam logic [1:0] REQ_MOTION = 2'd0;
  localparam logic [1:0] REQ_TALK   = 2'd1;
  localparam logic [1:0] REQ_COMMIT = 2'd2;
  localparam logic [1:0] REQ_FLUSH  = 2'd3;

  // Device register numbers
  localparam logic [1:0] REG_MOUSE = 2'd0;
  localparam logic [1:0] REG_ID    = 2'd3;

  // Register 3 first byte base
  localparam logic [7:0] REG3_BASE = 8'h60;

  // Configuration register indexes
  localparam logic CFG_ADDRESS = 1'b0;
  localparam logic CFG_HANDLER = 1'b1;

  // Reset values of the configuration registers
  localparam logic [3:0] ADDRESS_RESET = 4'd3;
  localparam logic [7:0] HANDLER_RESET = 8'd1;

  // Classified operation carried through the queue
  typedef enum logic [2:0] {
    OP_NOP,
    OP_MOTION,
    OP_TALK0,
    OP_TALK3,
    OP_COMMIT,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [1:0]        reg_num;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic [1:0]        button_state;
  } in_t;

  typedef struct packed {
    logic [1:0] byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       service_request;
  } out_t;

  typedef struct packed {
    op_t               op;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic [1:0]        buttons;
  } cmd_t;

  typedef struct packed {
    logic [3:0] device_address;
    logic [7:0] handler_id;
  } cfg_t;

endpackage

>>> hw/rtl/adbm_front.sv
// Front end: accepts input items and classifies them into queue commands.
// Depends on adbm_pkg.
module adbm_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  adbm_pkg::in_t in_item,
  output logic          push_valid,
  input  logic          push_ready,
  output adbm_pkg::cmd_t push_cmd
);

  // Hand the item straight to the queue when it has room
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // Classify request type and register number into one operation
  always_comb begin
    push_cmd.move_x  = in_item.move_x;
    push_cmd.move_y  = in_item.move_y;
    push_cmd.buttons = in_item.button_state;
    case (in_item.req_type)
      adbm_pkg::REQ_MOTION: begin
        push_cmd.op = adbm_pkg::OP_MOTION;
      end
      adbm_pkg::REQ_TALK: begin
        if (in_item.reg_num == adbm_pkg::REG_MOUSE) begin
          push_cmd.op = adbm_pkg::OP_TALK0;
        end else if (in_item.reg_num == adbm_pkg::REG_ID) begin
          push_cmd.op = adbm_pkg::OP_TALK3;
        end else begin
          push_cmd.op = adbm_pkg::OP_NOP;
        end
      end
      adbm_pkg::REQ_COMMIT: begin
        if (in_item.reg_num == adbm_pkg::REG_MOUSE) begin
          push_cmd.op = adbm_pkg::OP_COMMIT;
        end else begin
          push_cmd.op = adbm_pkg::OP_NOP;
        end
      end
      adbm_pkg::REQ_FLUSH: begin
        push_cmd.op = adbm_pkg::OP_FLUSH;
      end
      default: begin
        push_cmd.op = adbm_pkg::OP_NOP;
      end
    endcase
  end

endmodule

>>> hw/rtl/adbm_queue.sv
// Short command queue between the front and back ends.
// Depends on adbm_pkg for the command type.
module adbm_queue #(
  parameter int DEPTH = adbm_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  adbm_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output adbm_pkg::cmd_t pop_cmd
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  adbm_pkg::cmd_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/adbm_back.sv
// Back end: executes queued commands on the mouse state and registers results.
// Depends on adbm_pkg.
module adbm_back (
  input  logic           clk,
  input  logic           rst,
  input  adbm_pkg::cfg_t cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  adbm_pkg::cmd_t pop_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output adbm_pkg::out_t out_item
);

  logic signed [15:0] accum_x;
  logic signed [15:0] accum_y;
  logic [1:0]         buttons_now;
  logic [1:0]         buttons_reported;
  logic signed [6:0]  sent_x;
  logic signed [6:0]  sent_y;

  logic signed [15:0] accum_x_next;
  logic signed [15:0] accum_y_next;
  logic [1:0]         buttons_now_next;
  logic [1:0]         buttons_reported_next;
  logic signed [6:0]  sent_x_next;
  logic signed [6:0]  sent_y_next;
  adbm_pkg::out_t     result;
  logic               pending;
  logic               fire;

  // Add a signed byte to an accumulator, saturating at the 16-bit limits
  function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                 logic signed [7:0] d);
    logic signed [16:0] sum;
    sum = {a[15], a} + {{9{d[7]}}, d};
    if (sum[16] != sum[15]) begin
      sat_add = sum[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sat_add = sum[15:0];
    end
  endfunction

  // Clamp an accumulator to the seven-bit report range
  function automatic logic signed [6:0] clamp7(logic signed [15:0] a);
    if (a < -16'sd64) begin
      clamp7 = -7'sd64;
    end else if (a > 16'sd63) begin
      clamp7 = 7'sd63;
    end else begin
      clamp7 = a[6:0];
    end
  endfunction

  assign fire      = pop_valid && pop_ready;
  assign pop_ready = !out_valid || out_ready;
  assign pending   = (accum_x != '0) || (accum_y != '0) ||
                     (buttons_now != buttons_reported);

  // Work out next state and the result for the command at the queue head
  always_comb begin
    accum_x_next          = accum_x;
    accum_y_next          = accum_y;
    buttons_now_next      = buttons_now;
    buttons_reported_next = buttons_reported;
    sent_x_next           = sent_x;
    sent_y_next           = sent_y;
    result                = '0;
    case (pop_cmd.op)
      adbm_pkg::OP_MOTION: begin
        accum_x_next     = sat_add(accum_x, pop_cmd.move_x);
        accum_y_next     = sat_add(accum_y, pop_cmd.move_y);
        buttons_now_next = pop_cmd.buttons;
      end
      adbm_pkg::OP_TALK0: begin
        if (pending) begin
          sent_x_next        = clamp7(accum_x);
          sent_y_next        = clamp7(accum_y);
          result.byte_count  = 2'd2;
          result.first_byte  = {~buttons_now[0], sent_y_next};
          result.second_byte = {~buttons_now[1], sent_x_next};
        end else begin
          sent_x_next = '0;
          sent_y_next = '0;
        end
      end
      adbm_pkg::OP_TALK3: begin
        result.byte_count  = 2'd2;
        result.first_byte  = adbm_pkg::REG3_BASE + {4'b0, cfg.device_address};
        result.second_byte = cfg.handler_id;
      end
      adbm_pkg::OP_COMMIT: begin
        buttons_reported_next = buttons_now;
        accum_x_next = sat_add(accum_x, -{sent_x[6], sent_x});
        accum_y_next = sat_add(accum_y, -{sent_y[6], sent_y});
      end
      adbm_pkg::OP_FLUSH: begin
        accum_x_next          = '0;
        accum_y_next          = '0;
        buttons_now_next      = '0;
        buttons_reported_next = '0;
        sent_x_next           = '0;
        sent_y_next           = '0;
      end
      default: begin
      end
    endcase
    result.service_request = (accum_x_next != '0) || (accum_y_next != '0) ||
                             (buttons_now_next != buttons_reported_next);
  end

  // Update mouse state on each executed command
  always_ff @(posedge clk) begin
    if (rst) begin
      accum_x          <= '0;
      accum_y          <= '0;
      buttons_now      <= '0;
      buttons_reported <= '0;
      sent_x           <= '0;
      sent_y           <= '0;
    end else if (fire) begin
      accum_x          <= accum_x_next;
      accum_y          <= accum_y_next;
      buttons_now      <= buttons_now_next;
      buttons_reported <= buttons_reported_next;
      sent_x           <= sent_x_next;
      sent_y           <= sent_y_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

endmodule

>>> hw/rtl/adb_mouse_register_talk.sv
// Top level of the desktop-bus mouse register talk block.
// Depends on adbm_pkg, adbm_front, adbm_queue and adbm_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | input     | in_valid/in_ready  | in_item  (adbm_pkg::in_t)
//  out     | output    | out_valid/out_ready| out_item (adbm_pkg::out_t)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item
// is written into the queue, then executed from its head into the output register.
// The back end updates its state in one step per command, which sets the rate.
// Synchronous reset clears the queue, the mouse state and the output valid,
// and loads the address and handler registers with their defaults.
// The queue holds items while the output stalls; input ready drops when full.
module adb_mouse_register_talk #(
  parameter int QUEUE_DEPTH = adbm_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  adbm_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output adbm_pkg::out_t out_item,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  adbm_pkg::cfg_t cfg;
  adbm_pkg::cmd_t push_cmd;
  adbm_pkg::cmd_t pop_cmd;
  logic           push_valid;
  logic           push_ready;
  logic           pop_valid;
  logic           pop_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= adbm_pkg::ADDRESS_RESET;
      cfg.handler_id     <= adbm_pkg::HANDLER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        adbm_pkg::CFG_ADDRESS: cfg.device_address <= cfg_data[3:0];
        adbm_pkg::CFG_HANDLER: cfg.handler_id     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  adbm_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  adbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  adbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> bench/mouse_report_check.sv
`timescale 1ns / 1ps
// Report checker for the desktop-bus mouse register talk block.
// Watches the item, report and register ports, predicts each report and compares.
// Depends on adbm_pkg.
module mouse_report_check
  import adbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_t        in_item,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_t       out_item,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         outstanding
);

  // Shadow copy of the mouse state and the configuration
  logic [3:0]         dev_addr;
  logic [7:0]         handler;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic [1:0]         btn_now;
  logic [1:0]         btn_rep;
  logic signed [6:0]  sent_x;
  logic signed [6:0]  sent_y;
  out_t               expected_reports[$];
  int                 mismatches;

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [6:0] clamp7(int v);
    if (v < -64) return 7'sh40;
    if (v > 63) return 7'sh3f;
    return v[6:0];
  endfunction

  function automatic logic motion_pending();
    return acc_x != 0 || acc_y != 0 || btn_now != btn_rep;
  endfunction

  // Clear every piece of mouse state
  task automatic clear_mouse();
    acc_x = '0;
    acc_y = '0;
    btn_now = '0;
    btn_rep = '0;
    sent_x = '0;
    sent_y = '0;
  endtask

  // Advance the shadow state by one item and build the report it causes
  task automatic mouse_step(input in_t it, output out_t rep);
    rep = '0;
    case (it.req_type)
      REQ_MOTION: begin
        acc_x = sat16(int'(acc_x) + int'($signed(it.move_x)));
        acc_y = sat16(int'(acc_y) + int'($signed(it.move_y)));
        btn_now = it.button_state;
      end
      REQ_TALK: begin
        if (it.reg_num == REG_MOUSE) begin
          if (motion_pending()) begin
            sent_x = clamp7(int'(acc_x));
            sent_y = clamp7(int'(acc_y));
            rep.first_byte = {~btn_now[0], sent_y};
            rep.second_byte = {~btn_now[1], sent_x};
            rep.byte_count = 2'd2;
          end else begin
            sent_x = '0;
            sent_y = '0;
          end
        end else if (it.reg_num == REG_ID) begin
          rep.first_byte = REG3_BASE + {4'd0, dev_addr};
          rep.second_byte = handler;
          rep.byte_count = 2'd2;
        end
      end
      REQ_COMMIT: begin
        if (it.reg_num == REG_MOUSE) begin
          btn_rep = btn_now;
          acc_x = sat16(int'(acc_x) - int'(sent_x));
          acc_y = sat16(int'(acc_y) - int'(sent_y));
        end
      end
      REQ_FLUSH: clear_mouse();
    endcase
    rep.service_request = motion_pending();
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Track register writes, predict on each accepted item, check each report
  always @(posedge clk) begin
    out_t rep;
    out_t want;
    if (rst) begin
      dev_addr = ADDRESS_RESET;
      handler = HANDLER_RESET;
      clear_mouse();
      expected_reports.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ADDRESS) dev_addr = cfg_data[3:0];
        else handler = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none got %h", $time, out_item);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("byte_count", want.byte_count, out_item.byte_count);
          compare_field("first_byte", want.first_byte, out_item.first_byte);
          compare_field("second_byte", want.second_byte, out_item.second_byte);
          compare_field("service_request", want.service_request,
                        out_item.service_request);
        end
      end
      if (in_valid && in_ready) begin
        mouse_step(in_item, rep);
        expected_reports.push_back(rep);
      end
    end
    fail_count <= mismatches;
    outstanding <= expected_reports.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top of the bench for adb_mouse_register_talk: clock, reset, item stimulus, report
// back-pressure, register writes. Depends on adbm_pkg, the DUT and mouse_report_check.
module tb;
  import adbm_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_t        in_item;
  logic       out_valid;
  logic       out_ready;
  out_t       out_item;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         outstanding;
  int         send_idle_pct;
  int         recv_stall_pct;

  adb_mouse_register_talk dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mouse_report_check report_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  // Stall the report side at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic in_t make_item(logic [1:0] req, logic [1:0] rn,
                                    logic signed [7:0] dx, logic signed [7:0] dy,
                                    logic [1:0] btn);
    in_t it;
    it.req_type = req;
    it.reg_num = rn;
    it.move_x = dx;
    it.move_y = dy;
    it.button_state = btn;
    return it;
  endfunction

  function automatic in_t random_item(logic [1:0] req);
    logic [31:0] r;
    in_t it;
    r = $urandom;
    it = r[$bits(in_t)-1:0];
    it.req_type = req;
    return it;
  endfunction

  // Offer one item, idling first at the current rate, and hold it until taken
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every predicted report has come out
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly poll sequences, some identify talks, flushes and noise
  task automatic run_random(int count, int burst_len, logic signed [7:0] bx,
                            logic signed [7:0] by);
    in_t it;
    int sent;
    int pick;
    sent = 0;
    // Push both accumulators into saturation
    repeat (burst_len) begin
      it = random_item(REQ_MOTION);
      it.move_x = bx;
      it.move_y = by;
      send_item(it);
      sent++;
    end
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        repeat ($urandom_range(3)) begin
          send_item(random_item(REQ_MOTION));
          sent++;
        end
        it = random_item(REQ_TALK);
        it.reg_num = REG_MOUSE;
        send_item(it);
        sent++;
        if ($urandom_range(9) < 8) begin
          it = random_item(REQ_COMMIT);
          it.reg_num = REG_MOUSE;
          send_item(it);
          sent++;
        end
      end else if (pick < 72) begin
        it = random_item(REQ_TALK);
        it.reg_num = REG_ID;
        send_item(it);
        sent++;
      end else if (pick < 76) begin
        send_item(random_item(REQ_FLUSH));
        sent++;
      end else if (pick < 78) begin
        wait_for_reports();
      end else begin
        send_item(random_item(2'($urandom_range(3))));
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ADDRESS;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Identify talk with the reset address and handler
    send_item(make_item(REQ_TALK, REG_ID, 8'sd5, -8'sd5, 2'd1));
    wait_for_reports();
    write_register(CFG_ADDRESS, 8'hAF);
    write_register(CFG_HANDLER, 8'hFF);

    // Directed cases
    send_item(make_item(REQ_TALK, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_COMMIT, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_MOTION, 2'd3, 8'sd127, 8'sd127, 2'd3));
    send_item(make_item(REQ_MOTION, 2'd0, 8'sd127, -8'sd128, 2'd1));
    send_item(make_item(REQ_TALK, 2'd1, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_TALK, 2'd2, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_TALK, REG_MOUSE, -8'sd1, 8'sd1, 2'd2));
    send_item(make_item(REQ_COMMIT, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_COMMIT, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_COMMIT, 2'd1, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_COMMIT, REG_ID, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_MOTION, 2'd1, -8'sd128, -8'sd128, 2'd2));
    send_item(make_item(REQ_TALK, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_COMMIT, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_TALK, REG_ID, -8'sd1, -8'sd1, 2'd3));
    send_item(make_item(REQ_FLUSH, 2'd0, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_MOTION, 2'd2, 8'sd0, 8'sd0, 2'd1));
    send_item(make_item(REQ_TALK, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_COMMIT, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_TALK, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_COMMIT, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));
    send_item(make_item(REQ_MOTION, 2'd3, -8'sd1, 8'sd1, 2'd3));
    send_item(make_item(REQ_FLUSH, 2'd3, -8'sd128, 8'sd127, 2'd3));
    send_item(make_item(REQ_TALK, REG_MOUSE, 8'sd0, 8'sd0, 2'd0));

    // Random phases at different idle rates and register settings
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_reports();
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_register(CFG_ADDRESS, 8'h00);
          write_register(CFG_HANDLER, 8'h00);
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
          write_register(CFG_ADDRESS, 8'h0F);
          write_register(CFG_HANDLER, 8'hFF);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
          write_register(CFG_ADDRESS, 8'($urandom));
          write_register(CFG_HANDLER, 8'($urandom));
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
          write_register(CFG_ADDRESS, 8'($urandom));
          write_register(CFG_HANDLER, 8'($urandom));
        end
      endcase
      if (phase == 1) run_random(300, 260, 8'sd127, -8'sd128);
      else if (phase == 2) run_random(300, 260, -8'sd128, 8'sd127);
      else run_random(300, 0, 8'sd0, 8'sd0);
    end

    // Drain and give the verdict
    wait_for_reports();
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/adbm_pkg.sv
hw/rtl/adbm_front.sv
hw/rtl/adbm_queue.sv
hw/rtl/adbm_back.sv
hw/rtl/adb_mouse_register_talk.sv
bench/mouse_report_check.sv
bench/tb.sv
